// ===== sv/lgas_pkg.sv =====
// ----------------------------------------------------------------------------
// lgas_pkg
// shared types and constants of the glyph animation sequencer
// ----------------------------------------------------------------------------
package lgas_pkg;

    localparam int MAX_FRAMES_DEF    = 8;
    localparam int MAX_CHAR_ROWS_DEF = 2;

    localparam int WORD_W  = 16;
    localparam int CFG_W   = 8;
    localparam int CFG_AW  = 3;
    localparam int COL_W   = 5;
    localparam int PIX_ROWS = 8;

    typedef enum logic [CFG_AW-1:0] {
        CFG_TICK_DIVISOR = 3'd0,
        CFG_FRAME_TOTAL  = 3'd1,
        CFG_GLYPH_HEIGHT = 3'd2,
        CFG_GLYPH_WIDTH  = 3'd3,
        CFG_FIRST_GLYPH  = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef struct packed {
        logic       go;
        logic [1:0] rows;
        logic [1:0] cols;
        logic [2:0] code;
    } t_lgas_start;

endpackage

// ===== sv/lcd_glyph_animation_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcd_glyph_animation_sequencer
// frame store, prescaler and frame index around the row write walker
// ----------------------------------------------------------------------------
// load items and ticks that cause no update are taken without dropping o_ready
// a frame update passes walker, read stage and output register to its first row write,
// then shows one row write per cycle while the output is ready: up to 48 writes,
// at the pace of the single read port of the frame store; no item is taken meanwhile
// reset restores the registers and clears counter and frame index; the store is not cleared
module lcd_glyph_animation_sequencer
    import lgas_pkg::*;
#(
    parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
    parameter int MAX_CHAR_ROWS = MAX_CHAR_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_operation,
    input  logic [2:0]        i_frame_number,
    input  logic [3:0]        i_word_index,
    input  logic [15:0]       i_word_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_char_code,
    output logic [2:0]        o_pixel_row,
    output logic [7:0]        o_row_bits,
    output logic              o_last
);

    localparam int Wpf   = MAX_CHAR_ROWS * PIX_ROWS;
    localparam int Depth = MAX_FRAMES * Wpf;
    localparam int AW    = $clog2(Depth);
    localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [7:0]    r_tick_divisor;
    logic [3:0]    r_frame_total;
    logic [1:0]    r_glyph_height;
    logic [1:0]    r_glyph_width;
    logic [2:0]    r_first_glyph;

    logic [7:0]    r_tick;
    logic [FW-1:0] r_frame;
    logic          r_busy;

    logic [WORD_W-1:0] mem [Depth];
    logic [WORD_W-1:0] r_rdata;

    logic          w_acc;
    logic          w_load;
    logic          w_tick;
    logic [7:0]    n_tick;
    logic          w_update;
    logic [1:0]    w_rows;
    logic          w_emit;
    logic          w_wrap;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic          w_done;
    t_lgas_start   w_start;

    assign o_ready = !r_busy;
    assign w_acc   = i_valid && !r_busy;
    assign w_load  = w_acc && (i_operation == OP_LOAD);
    assign w_tick  = w_acc && (i_operation == OP_TICK);
    assign n_tick  = r_tick + 8'd1;
    assign w_update = w_tick && (n_tick == r_tick_divisor);

    assign w_rows = (32'(r_glyph_height) > MAX_CHAR_ROWS) ? 2'(MAX_CHAR_ROWS)
                                                          : r_glyph_height;
    assign w_emit = (w_rows != 2'd0) && (r_glyph_width != 2'd0);
    assign w_wrap = (r_frame_total == 4'd0)
                 || (32'(r_frame) + 1 >= 32'(r_frame_total))
                 || (32'(r_frame) + 1 >= MAX_FRAMES);

    assign w_start.go   = w_update && w_emit;
    assign w_start.rows = w_rows;
    assign w_start.cols = r_glyph_width;
    assign w_start.code = r_first_glyph;

    assign w_we    = w_load && (32'(i_frame_number) < MAX_FRAMES)
                            && (32'(i_word_index) < Wpf);
    assign w_waddr = AW'(32'(i_frame_number) * Wpf + 32'(i_word_index));
    assign w_done  = o_valid && i_ready && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_divisor <= 8'd1;
            r_frame_total  <= 4'd1;
            r_glyph_height <= 2'd1;
            r_glyph_width  <= 2'd1;
            r_first_glyph  <= 3'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TICK_DIVISOR: r_tick_divisor <= i_cfg_wdata;
                CFG_FRAME_TOTAL:  r_frame_total  <= i_cfg_wdata[3:0];
                CFG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_wdata[1:0];
                CFG_GLYPH_WIDTH:  r_glyph_width  <= i_cfg_wdata[1:0];
                CFG_FIRST_GLYPH:  r_first_glyph  <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= 8'd0;
            r_frame <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (w_tick) begin
                r_tick <= w_update ? 8'd0 : n_tick;
            end
            if (w_update) begin
                r_frame <= w_wrap ? '0 : r_frame + FW'(1);
            end
            if (w_start.go) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= i_word_data;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    lgas_seq #(
        .MAX_FRAMES    (MAX_FRAMES),
        .MAX_CHAR_ROWS (MAX_CHAR_ROWS),
        .FW            (FW),
        .AW            (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_frame     (r_frame),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (r_rdata),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_pixel_row (o_pixel_row),
        .o_row_bits  (o_row_bits),
        .o_last      (o_last)
    );

endmodule

// ===== sv/lgas_seq.sv =====
// ----------------------------------------------------------------------------
// lgas_seq
// walks one frame update: issues store reads and registers the row writes
// ----------------------------------------------------------------------------
module lgas_seq
    import lgas_pkg::*;
#(
    parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
    parameter int MAX_CHAR_ROWS = MAX_CHAR_ROWS_DEF,
    parameter int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    parameter int AW = $clog2(MAX_FRAMES * MAX_CHAR_ROWS * PIX_ROWS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lgas_start       i_start,
    input  logic [FW-1:0]     i_frame,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  logic [WORD_W-1:0] i_rd_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_char_code,
    output logic [2:0]        o_pixel_row,
    output logic [7:0]        o_row_bits,
    output logic              o_last
);

    localparam int Wpf = MAX_CHAR_ROWS * PIX_ROWS;

    logic          r_act;
    logic [FW-1:0] r_frame;
    logic [1:0]    r_rows;
    logic [1:0]    r_cols;
    logic          r_byte;
    logic [1:0]    r_row;
    logic [1:0]    r_col;
    logic [2:0]    r_pix;
    logic [2:0]    r_code;

    logic          r_s1_v;
    logic [2:0]    r_s1_code;
    logic [2:0]    r_s1_pix;
    logic [1:0]    r_s1_col;
    logic          r_s1_last;

    logic          r_ov;
    logic [2:0]    r_o_code;
    logic [2:0]    r_o_pix;
    logic [7:0]    r_o_bits;
    logic          r_o_last;

    logic          w_adv;
    logic          w_issue;
    logic          w_last_issue;
    logic [4:0]    w_slice;
    logic [7:0]    n_bits;

    assign w_adv        = !r_ov || i_ready;
    assign w_issue      = r_act && (w_adv || !r_s1_v);
    assign w_last_issue = (r_row == r_rows - 2'd1) && (r_col == 2'd0) && (r_pix == 3'd7);

    assign o_rd_en   = w_issue;
    assign o_rd_addr = AW'(32'(r_frame) * Wpf + 32'({r_row, r_pix}));

    always_comb begin
        case (r_s1_col)
            2'd0:    w_slice = i_rd_data[0 +: COL_W];
            2'd1:    w_slice = i_rd_data[COL_W +: COL_W];
            2'd2:    w_slice = i_rd_data[2*COL_W +: COL_W];
            default: w_slice = '0;
        endcase
        n_bits = r_byte ? i_rd_data[7:0] : {3'b000, w_slice};
    end

    // walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (i_start.go) begin
            r_act   <= 1'b1;
            r_frame <= i_frame;
            r_rows  <= i_start.rows;
            r_cols  <= i_start.cols;
            r_byte  <= (i_start.cols == 2'd1);
            r_row   <= 2'd0;
            r_col   <= i_start.cols - 2'd1;
            r_pix   <= 3'd0;
            r_code  <= i_start.code;
        end else if (w_issue) begin
            r_pix <= r_pix + 3'd1;
            if (r_pix == 3'd7) begin
                r_code <= r_code + 3'd1;
                if (r_col == 2'd0) begin
                    r_col <= r_cols - 2'd1;
                    r_row <= r_row + 2'd1;
                end else begin
                    r_col <= r_col - 2'd1;
                end
            end
            if (w_last_issue) begin
                r_act <= 1'b0;
            end
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_issue) begin
            r_s1_v <= 1'b1;
        end else if (w_adv) begin
            r_s1_v <= 1'b0;
        end
        if (w_issue) begin
            r_s1_code <= r_code;
            r_s1_pix  <= r_pix;
            r_s1_col  <= r_col;
            r_s1_last <= w_last_issue;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_s1_v;
        end
        if (w_adv && r_s1_v) begin
            r_o_code <= r_s1_code;
            r_o_pix  <= r_s1_pix;
            r_o_bits <= n_bits;
            r_o_last <= r_s1_last;
        end
    end

    assign o_valid     = r_ov;
    assign o_char_code = r_o_code;
    assign o_pixel_row = r_o_pix;
    assign o_row_bits  = r_o_bits;
    assign o_last      = r_o_last;

endmodule
